@@ hdl/nlme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_pkg
// Shared types, status codes and the Manchester expansion for the
// nearest-level Manchester encoder.
// ----------------------------------------------------------------------------
package nlme_pkg;

  localparam logic [2:0] ST_ENCODED   = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOMATCH   = 3'd4;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] voltage;
    logic        [7:0]  level_code;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  code;
    logic [15:0] symbol_word;
  } result_t;

  // Job handed from the front queue to the scan engine
  typedef struct packed {
    logic               is_load;
    logic signed [15:0] voltage;
    logic        [7:0]  level_code;
  } job_t;

  // Bit 1 becomes pair 01, bit 0 becomes pair 10, bit 0 in the low pair
  function automatic logic [15:0] manchester(input logic [7:0] c);
    logic [15:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[2*i]   = c[i];
      w[2*i+1] = ~c[i];
    end
    return w;
  endfunction

endpackage

@@ hdl/nearest_level_manchester_encoder.sv @@
`timescale 1ns / 1ps
// The scan engine reads one stored level per cycle from its single RAM read
// port and finishes each item before it takes the next. A two-entry input
// queue takes items while the engine scans. Reset (rst, synchronous) empties
// table, queue and output; max_distance returns to 65535.
// ----------------------------------------------------------------------------
// nearest_level_manchester_encoder
// Level table with load and nearest-level encode, giving Manchester words.
// ----------------------------------------------------------------------------
module nearest_level_manchester_encoder #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  nlme_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output nlme_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import nlme_pkg::*;

  logic        max_distance_en;
  logic [15:0] max_distance;
  logic        job_valid;
  logic        job_take;
  job_t        job;

  assign cfg_ready       = 1'b1;
  assign max_distance_en = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= 16'hFFFF;
    end else if (max_distance_en) begin
      max_distance <= cfg_data;
    end
  end

  nlme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  nlme_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .max_distance(max_distance),
    .job_valid   (job_valid),
    .job_take    (job_take),
    .job         (job),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ hdl/nlme_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nlme_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/nlme_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_front
// Accepts input items, classifies them as load or encode and holds them in a
// two-entry queue for the scan engine.
// ----------------------------------------------------------------------------
module nlme_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  nlme_pkg::item_t item,
  output logic          job_valid,
  input  logic          job_take,
  output nlme_pkg::job_t  job
);
  import nlme_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign pop        = job_take && job_valid;
  assign job_valid  = (count != 2'd0);
  assign job        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].is_load    <= (item.mode == MODE_LOAD);
      slots[wr_ptr].voltage    <= item.voltage;
      slots[wr_ptr].level_code <= item.level_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/nlme_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_engine
// Scans the stored levels one per cycle for a job, then appends the pair or
// picks the nearest level, and places the result in the output register.
// ----------------------------------------------------------------------------
module nlme_engine #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      max_distance,
  input  logic             job_valid,
  output logic             job_take,
  input  nlme_pkg::job_t   job,
  output logic             result_valid,
  input  logic             result_stall,
  output nlme_pkg::result_t result
);
  import nlme_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      used;
  logic               pend;
  job_t               cur;
  logic [15:0]        best_d;
  logic signed [15:0] best_v;
  logic [7:0]         best_c;
  logic               found;
  logic               dup;

  logic               ram_we;
  logic [23:0]        ram_rdata;
  logic signed [15:0] lv;
  logic [7:0]         lc;
  logic [16:0]        diff;
  logic [15:0]        gap;
  logic               better;
  logic               out_free;
  logic               finish;
  result_t            res_next;

  nlme_ram #(
    .WIDTH(24),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(used[AW-1:0]),
    .wdata({cur.voltage, cur.level_code}),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign lv = ram_rdata[23:8];
  assign lc = ram_rdata[7:0];

  always_comb begin
    diff   = {cur.voltage[15], cur.voltage} - {lv[15], lv};
    gap    = diff[16] ? 16'(-diff) : diff[15:0];
    better = (gap < best_d) || (found && gap == best_d && lv < best_v);
  end

  assign out_free = !result_valid || !result_stall;
  assign job_take = (state == S_IDLE) && job_valid;
  assign finish   = (state == S_DONE) && out_free;
  assign ram_we   = finish && cur.is_load && !dup && (used != DEPTH_C);

  always_comb begin
    res_next = '0;
    if (cur.is_load) begin
      if (dup) begin
        res_next.status = ST_DUPLICATE;
      end else if (used == DEPTH_C) begin
        res_next.status = ST_FULL;
      end else begin
        res_next.status = ST_LOADED;
      end
    end else if (found) begin
      res_next.status      = ST_ENCODED;
      res_next.code        = best_c;
      res_next.symbol_word = manchester(best_c);
    end else begin
      res_next.status = ST_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (finish) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      used         <= '0;
      pend         <= 1'b0;
      best_d       <= '0;
      best_v       <= '0;
      best_c       <= '0;
      found        <= 1'b0;
      dup          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            idx    <= '0;
            pend   <= 1'b0;
            best_d <= max_distance;
            found  <= 1'b0;
            dup    <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance the read address; the RAM returns its data through a register
          if (idx < used) begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
          if (pend) begin
            if (lv == cur.voltage) begin
              dup <= 1'b1;
            end
            if (better) begin
              best_d <= gap;
              best_v <= lv;
              best_c <= lc;
              found  <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (ram_we) begin
              used <= used + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/nlme_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_props
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nlme_props (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input nlme_pkg::result_t result
);
  import nlme_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= ST_NOMATCH)
    else $error("status code out of range");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_ENCODED |->
      result.code == 8'd0 && result.symbol_word == 16'd0)
    else $error("code or symbol word set without an encode");

  a_manchester: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_ENCODED |->
      result.symbol_word == manchester(result.code))
    else $error("symbol word does not match code");

endmodule

bind nearest_level_manchester_encoder nlme_props u_chk (.*);

@@ tb/nlme_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlme_checker
// Watches the item, result and register channels of the nearest-level
// Manchester encoder. It keeps its own level table and distance limit, works
// out the result of every accepted item, and compares each result transfer
// with the oldest outstanding prediction. It reports the number of failures.
// ----------------------------------------------------------------------------
module nlme_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  nlme_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  nlme_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output int                pending,
  output int                fail_count
);

  import nlme_pkg::*;

  logic signed [15:0] level_volts [TABLE_DEPTH];
  logic        [7:0]  level_codes [TABLE_DEPTH];
  int                 levels_held;
  logic        [15:0] match_limit;
  result_t            pending_results [$];
  int                 mismatches = 0;

  function automatic logic [15:0] expand_code(input logic [7:0] c);
    logic [15:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[2*i +: 2] = c[i] ? 2'b01 : 2'b10;
    end
    return w;
  endfunction

  // Update the table for a load, or search it for an encode
  function automatic result_t quantize(input item_t it);
    result_t            r;
    logic signed [15:0] sample;
    logic               found;
    int                 best_d;
    int                 d;
    logic signed [15:0] best_v;
    logic        [7:0]  best_c;
    r = '0;
    sample = $signed(it.voltage);
    if (it.mode == MODE_LOAD) begin
      for (int i = 0; i < levels_held; i++) begin
        if (level_volts[i] == sample) begin
          r.status = ST_DUPLICATE;
          return r;
        end
      end
      if (levels_held >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      level_volts[levels_held] = sample;
      level_codes[levels_held] = it.level_code;
      levels_held++;
      r.status = ST_LOADED;
      return r;
    end
    found  = 1'b0;
    best_d = int'(match_limit);
    best_v = '0;
    best_c = '0;
    for (int i = 0; i < levels_held; i++) begin
      d = int'(sample) - int'(level_volts[i]);
      if (d < 0) d = -d;
      // strictly closer, or equally close and lower in voltage
      if (d < best_d || (found && d == best_d && level_volts[i] < best_v)) begin
        best_d = d;
        best_v = level_volts[i];
        best_c = level_codes[i];
        found  = 1'b1;
      end
    end
    if (!found) begin
      r.status = ST_NOMATCH;
    end else begin
      r.status      = ST_ENCODED;
      r.code        = best_c;
      r.symbol_word = expand_code(best_c);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      levels_held = 0;
      match_limit = 16'hFFFF;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) match_limit = cfg_data;
      if (item_valid && !item_stall) pending_results.push_back(quantize(item));
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got status %0d code %02h %s %04h",
                   $time, result.status, result.code, "symbol", result.symbol_word);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status || result.code !== want.code ||
              result.symbol_word !== want.symbol_word) begin
            mismatches++;
            $display("%0t: mismatch: expected status %0d code %02h symbol %04h,",
                     $time, want.status, want.code, want.symbol_word);
            $display("%0t:   got status %0d code %02h symbol %04h",
                     $time, result.status, result.code, result.symbol_word);
          end
        end
      end
    end
    pending    = pending_results.size();
    fail_count = mismatches + pending;
  end

endmodule

@@ tb/tb_nearest_level_manchester_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_level_manchester_encoder
// Drives loads and encodes into the nearest-level Manchester encoder through
// several distance limits: a directed opening, then random traffic that grows
// the level table until it is full. Both sides idle at random, and once the
// result side holds off long enough to back the block up. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_nearest_level_manchester_encoder;

  import nlme_pkg::*;

  localparam int TABLE_DEPTH     = 256;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int TAIL_CYCLES     = TABLE_DEPTH + 8;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = '0;

  int                 pending;
  int                 fail_count;
  logic               steady        = 1'b0;
  int                 hold_requests = 0;
  logic        [15:0] max_dist_now  = 16'hFFFF;
  logic signed [15:0] level_list [$];
  bit                 stored [int];

  always #10 clk = ~clk;

  nearest_level_manchester_encoder #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  nlme_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) check_encoder (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // Offer one item and hold it until the transfer
  task automatic offer(input logic mode_bit, input logic signed [15:0] volts,
                       input logic [7:0] code_byte);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 13) begin
      item_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    item_valid = 1'b1;
    item       = '{mode: mode_bit, voltage: volts, level_code: code_byte};
    do @(posedge clk); while (item_stall);
    if (mode_bit == MODE_LOAD && !stored.exists(int'(volts)) &&
        level_list.size() < TABLE_DEPTH) begin
      stored[int'(volts)] = 1'b1;
      level_list.push_back(volts);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_max_distance(input logic [15:0] limit);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid    = 1'b0;
    max_dist_now = limit;
  endtask

  function automatic logic signed [15:0] pick_level();
    return level_list[$urandom_range(level_list.size() - 1)];
  endfunction

  task automatic random_item(input int load_pct);
    int                 r;
    int                 off;
    int                 span;
    logic signed [15:0] v;
    if ($urandom_range(99) < load_pct) begin
      if (level_list.size() != 0 && $urandom_range(99) < 30) v = pick_level();
      else v = 16'($urandom);
      offer(MODE_LOAD, v, 8'($urandom));
    end else begin
      r = $urandom_range(99);
      if (level_list.size() == 0 || r < 20) begin
        v = 16'($urandom);
      end else if (r < 40) begin
        // land on or just inside the edge of the match window
        off = $urandom_range(1) ? int'(max_dist_now) : int'(max_dist_now) - 1;
        if ($urandom_range(1)) off = -off;
        v = 16'(int'(pick_level()) + off);
      end else if (r < 50) begin
        v = 16'((int'(pick_level()) + int'(pick_level())) >>> 1);
      end else begin
        span = max_dist_now < 2000 ? int'(max_dist_now) + 2 : 2000;
        v = 16'(int'(pick_level()) + int'($urandom_range(2 * span)) - span);
      end
      offer(MODE_ENCODE, v, 8'($urandom));
    end
  endtask

  task automatic random_phase(input int count, input int load_pct);
    logic signed [15:0] a;
    int                 half_gap;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 6) begin
        // two levels and a sample midway between them
        a        = 16'($urandom);
        half_gap = $urandom_range(400, 1);
        offer(MODE_LOAD, a, 8'($urandom));
        offer(MODE_LOAD, 16'(int'(a) + 2 * half_gap), 8'($urandom));
        offer(MODE_ENCODE, 16'(int'(a) + half_gap), 8'($urandom));
      end else begin
        random_item(load_pct);
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off when asked
  initial begin : receiver
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        result_stall = !steady && ($urandom_range(99) < 13);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] v;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    offer(MODE_ENCODE, 16'h0000, 8'h3C);   // empty table
    offer(MODE_LOAD,   16'h8000, 8'h00);
    offer(MODE_ENCODE, 16'h7FFF, 8'hC3);   // full span away, not inside the limit
    offer(MODE_ENCODE, 16'h7FFE, 8'h00);
    offer(MODE_LOAD,   16'h7FFF, 8'hFF);
    offer(MODE_LOAD,   16'h0000, 8'hA5);
    offer(MODE_LOAD,   16'h0000, 8'h5A);   // repeated voltage, first load stays
    offer(MODE_ENCODE, 16'h8000, 8'hFF);
    offer(MODE_ENCODE, 16'h7FFF, 8'h00);
    offer(MODE_ENCODE, 16'h4000, 8'h00);
    offer(MODE_ENCODE, 16'hC000, 8'h00);   // equal distance, lower level wins
    offer(MODE_LOAD,   16'd100,  8'h11);
    offer(MODE_LOAD,   16'd200,  8'h22);
    offer(MODE_ENCODE, 16'd150,  8'h00);
    set_max_distance(16'd1);
    offer(MODE_ENCODE, 16'h0000, 8'h00);
    offer(MODE_ENCODE, 16'h0001, 8'h00);
    offer(MODE_ENCODE, 16'hFFFF, 8'h00);
    set_max_distance(16'd0);
    offer(MODE_ENCODE, 16'h0000, 8'h00);
    offer(MODE_LOAD,   16'd300,  8'h33);
    offer(MODE_ENCODE, 16'd300,  8'h00);
    set_max_distance(16'hFFFF);
    offer(MODE_ENCODE, 16'd300,  8'h00);

    set_max_distance(16'($urandom_range(65535, 1)));
    random_phase(250, 25);

    set_max_distance(16'd40);
    steady = 1'b1;
    random_phase(300, 15);
    steady = 1'b0;

    // back the block up while items keep coming
    set_max_distance(16'($urandom_range(65535, 1)));
    hold_requests++;
    random_phase(300, 10);

    set_max_distance(16'd1000);
    while (level_list.size() < TABLE_DEPTH) begin
      if ($urandom_range(99) < 20) begin
        random_item(0);
      end else begin
        do v = 16'($urandom); while (stored.exists(int'(v)));
        offer(MODE_LOAD, v, 8'($urandom));
      end
    end
    random_phase(30, 50);

    set_max_distance(16'hFFFF);
    random_phase(250, 20);

    set_max_distance(16'd1);
    random_phase(200, 10);

    set_max_distance(16'($urandom_range(65535, 1)));
    random_phase(250, 15);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
